// ===== src/dwps_pkg.sv =====
// Package for the dual wheel PI speed controller with left and right synchronization.
// Holds the register index codes, the configuration and queue entry types and sizes.
// No dependencies; the top level, front and back files import it, dwps_queue does not.
package dwps_pkg;

   localparam int MID_DEPTH_DEFAULT = 2;
   localparam int OUT_DEPTH_DEFAULT = 4;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // Signed width of one gain times one error, integral or speed difference.
   localparam int PROD_WIDTH = 26;
   // Signed width of the duty sum before saturation.
   localparam int SUM_WIDTH  = 27;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BASE_DUTY      = 3'd0,
      CSR_LEFT_TARGET    = 3'd1,
      CSR_RIGHT_TARGET   = 3'd2,
      CSR_SPEED_KP       = 3'd3,
      CSR_SPEED_KI       = 3'd4,
      CSR_SYNC_GAIN      = 3'd5,
      CSR_INTEGRAL_BOUND = 3'd6,
      CSR_DUTY_MAX       = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic        [15:0] base_duty;
      logic signed [14:0] left_target;
      logic signed [14:0] right_target;
      logic        [7:0]  speed_kp;
      logic        [7:0]  speed_ki;
      logic        [7:0]  sync_gain;
      logic        [14:0] integral_bound;
      logic        [15:0] duty_max;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] left_err;
      logic signed [15:0] right_err;
      logic signed [15:0] left_integral;
      logic signed [15:0] right_integral;
      logic signed [15:0] speed_diff;
   } mid_type;

   typedef struct packed {
      logic [15:0] left_pwm;
      logic [15:0] right_pwm;
   } duty_type;

endpackage

// ===== src/dual_wheel_pi_speed_sync.sv =====
// Top level of the dual wheel PI speed controller with left and right synchronization.
// Depends on dwps_pkg, dwps_front, dwps_queue and dwps_back.
//
// Usage: each request transaction is one control period with the measured left and
// right wheel speeds. It is taken at a clock edge with req_push high and req_full low,
// and yields exactly one response transaction with the two saturated duties, shown
// while rsp_empty is low and taken at an edge with rsp_pop high.
// A taken request passes through the middle queue (with both updated integrals), the
// gain product stage and the output queue. Throughput is one transaction per cycle
// while the receiver keeps popping; the front updates both integrals in the cycle of
// acceptance and the back holds one product stage followed by the output queue.
// The csr channel writes one register per transaction at csr_valid high; csr_ready is
// always high. The user must write registers only while no transaction is in flight; the block does not enforce it.
// Reset loads the register defaults, clears both integrals and empties both queues.
// When the receiver stalls, up to four results wait in the output queue and the product
// stage together, two more in the middle queue, and then req_full rises.
module dual_wheel_pi_speed_sync
   import dwps_pkg::*;
#(
   parameter int MID_DEPTH = MID_DEPTH_DEFAULT,
   parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic signed [14:0]         req_left_speed,
   input  logic signed [14:0]         req_right_speed,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [15:0]                rsp_left_duty,
   output logic [15:0]                rsp_right_duty,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type                      cfg_ff, cfg_in;
   logic                         accept;
   mid_type                      front_item, mid_item;
   logic                         mid_pop;
   logic                         mid_empty;
   logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_BASE_DUTY:      cfg_in.base_duty      = csr_data;
            CSR_LEFT_TARGET:    cfg_in.left_target    = csr_data[14:0];
            CSR_RIGHT_TARGET:   cfg_in.right_target   = csr_data[14:0];
            CSR_SPEED_KP:       cfg_in.speed_kp       = csr_data[7:0];
            CSR_SPEED_KI:       cfg_in.speed_ki       = csr_data[7:0];
            CSR_SYNC_GAIN:      cfg_in.sync_gain      = csr_data[7:0];
            CSR_INTEGRAL_BOUND: cfg_in.integral_bound = csr_data[14:0];
            CSR_DUTY_MAX:       cfg_in.duty_max       = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_duty      <= 16'd500;
         cfg_ff.left_target    <= 15'sd50;
         cfg_ff.right_target   <= 15'sd50;
         cfg_ff.speed_kp       <= 8'd1;
         cfg_ff.speed_ki       <= 8'd1;
         cfg_ff.sync_gain      <= 8'd1;
         cfg_ff.integral_bound <= 15'd500;
         cfg_ff.duty_max       <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dwps_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .left_speed  (req_left_speed),
      .right_speed (req_right_speed),
      .item        (front_item)
   );

   dwps_queue #(
      .WIDTH ($bits(mid_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_item),
      .pop       (mid_pop),
      .pop_data  (mid_item),
      .full      (req_full),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   dwps_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .mid_empty      (mid_empty),
      .mid_item       (mid_item),
      .mid_pop        (mid_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_left_duty  (rsp_left_duty),
      .rsp_right_duty (rsp_right_duty)
   );

   // The middle queue count is only consulted here to check that it tracks empty.
   a_mid_empty_count: assert property (@(posedge clock) disable iff (reset)
      mid_empty == (mid_count == '0))
      else $error("middle queue empty flag disagrees with its count");

endmodule

// ===== src/dwps_queue.sv =====
// Small register-based first-in first-out queue with a fill count.
// Depends on nothing; used between the front and back parts and at the output.
module dwps_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/dwps_front.sv =====
// Front part: forms the speed errors and speed difference of each accepted transaction
// and keeps the two clamped integrals. Depends on dwps_pkg.
module dwps_front
   import dwps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               accept,
   input  logic signed [14:0] left_speed,
   input  logic signed [14:0] right_speed,
   output mid_type            item
);

   logic signed [15:0] left_int_ff, left_int_in;
   logic signed [15:0] right_int_ff, right_int_in;
   logic signed [15:0] left_err;
   logic signed [15:0] right_err;
   logic signed [16:0] limit;

   function automatic logic signed [15:0] clamp_acc(
      input logic signed [15:0] integ,
      input logic signed [15:0] err,
      input logic signed [16:0] lim
   );
      logic signed [16:0] acc;
      acc = 17'(integ) + 17'(err);
      if (acc > lim) begin
         acc = lim;
      end else if (acc < -lim) begin
         acc = -lim;
      end
      return acc[15:0];
   endfunction

   assign limit     = $signed({2'b00, cfg.integral_bound});
   assign left_err  = 16'(cfg.left_target) - 16'(left_speed);
   assign right_err = 16'(cfg.right_target) - 16'(right_speed);

   always_comb begin
      left_int_in  = left_int_ff;
      right_int_in = right_int_ff;
      if (accept) begin
         left_int_in  = clamp_acc(left_int_ff, left_err, limit);
         right_int_in = clamp_acc(right_int_ff, right_err, limit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_int_ff  <= '0;
         right_int_ff <= '0;
      end else begin
         left_int_ff  <= left_int_in;
         right_int_ff <= right_int_in;
      end
   end

   assign item.left_err       = left_err;
   assign item.right_err      = right_err;
   assign item.left_integral  = left_int_in;
   assign item.right_integral = right_int_in;
   assign item.speed_diff     = 16'(left_speed) - 16'(right_speed);

endmodule

// ===== src/dwps_back.sv =====
// Back part: multiplies by the gains in one registered stage, then sums, saturates and
// queues the duties for the result channel. Depends on dwps_pkg and dwps_queue.
module dwps_back
   import dwps_pkg::*;
#(
   parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        mid_empty,
   input  mid_type     mid_item,
   output logic        mid_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_left_duty,
   output logic [15:0] rsp_right_duty
);

   localparam int CW = $clog2(OUT_DEPTH+1);

   logic                         s1_valid_ff, s1_valid_in;
   logic signed [PROD_WIDTH-1:0] left_p_ff, left_i_ff, right_p_ff, right_i_ff, sync_ff;
   logic signed [PROD_WIDTH-1:0] kp_ext, ki_ext, sg_ext;
   logic [CW-1:0]                out_count;
   logic                         out_full;
   logic                         issue;
   logic signed [SUM_WIDTH-1:0]  left_sum, right_sum, base_ext;
   duty_type                     duty_item, duty_head;

   function automatic logic [15:0] sat_duty(
      input logic signed [SUM_WIDTH-1:0] d,
      input logic [15:0]                 dmax
   );
      logic [15:0] r;
      if (d < 0) begin
         r = '0;
      end else if (d > $signed({{(SUM_WIDTH-16){1'b0}}, dmax})) begin
         r = dmax;
      end else begin
         r = d[15:0];
      end
      return r;
   endfunction

   assign issue       = !mid_empty && (({1'b0, out_count} + (CW+1)'(s1_valid_ff))
                                       < (CW+1)'(OUT_DEPTH));
   assign mid_pop     = issue;
   assign s1_valid_in = issue;

   assign kp_ext = PROD_WIDTH'($signed({1'b0, cfg.speed_kp}));
   assign ki_ext = PROD_WIDTH'($signed({1'b0, cfg.speed_ki}));
   assign sg_ext = PROD_WIDTH'($signed({1'b0, cfg.sync_gain}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         left_p_ff  <= kp_ext * PROD_WIDTH'(mid_item.left_err);
         left_i_ff  <= ki_ext * PROD_WIDTH'(mid_item.left_integral);
         right_p_ff <= kp_ext * PROD_WIDTH'(mid_item.right_err);
         right_i_ff <= ki_ext * PROD_WIDTH'(mid_item.right_integral);
         sync_ff    <= sg_ext * PROD_WIDTH'(mid_item.speed_diff);
      end
   end

   assign base_ext  = $signed({{(SUM_WIDTH-16){1'b0}}, cfg.base_duty});
   assign left_sum  = base_ext + SUM_WIDTH'(left_p_ff) + SUM_WIDTH'(left_i_ff)
                      - SUM_WIDTH'(sync_ff);
   assign right_sum = base_ext + SUM_WIDTH'(right_p_ff) + SUM_WIDTH'(right_i_ff)
                      + SUM_WIDTH'(sync_ff);

   assign duty_item.left_pwm  = sat_duty(left_sum, cfg.duty_max);
   assign duty_item.right_pwm = sat_duty(right_sum, cfg.duty_max);

   dwps_queue #(
      .WIDTH ($bits(duty_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (duty_item),
      .pop       (rsp_pop),
      .pop_data  (duty_head),
      .full      (out_full),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   assign rsp_left_duty  = duty_head.left_pwm;
   assign rsp_right_duty = duty_head.right_pwm;

   // The issue credit must leave room in the output queue for the product stage.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !out_full)
      else $error("product stage pushed into a full output queue");

   a_issue_fills_stage: assert property (@(posedge clock) disable iff (reset)
      issue |=> s1_valid_ff)
      else $error("issued transaction did not reach the product stage");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (({1'b0, out_count} + (CW+1)'(s1_valid_ff)) <= (CW+1)'(OUT_DEPTH)))
      else $error("output queue and product stage exceed the output queue depth");

endmodule
